FILE: src/ght_pkg.sv
package ght_pkg;

    // Command codes of the input item.
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_CHECK   = 2'd2;

    // Field widths of a handle: serial in 31:16, category in 15:14, slot in 13:0.
    localparam int HANDLE_W  = 32;
    localparam int HOUT_W    = 31;
    localparam int SERIAL_W  = 15;
    localparam int SERFLD_W  = 16;
    localparam int CAT_W     = 2;
    localparam int SLOT_W    = 14;
    localparam int USED_W    = 15;
    localparam int CMD_W     = 2;

    localparam logic [SERIAL_W-1:0] SERIAL_MAX   = 15'h7fff;
    localparam logic [SERIAL_W-1:0] SERIAL_FIRST = 15'h0001;

    // Free-slot bitmap word: one bit per slot, 1 means free.
    localparam int WORD_W = 32;
    localparam int WBIT_W = 5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_rd;
        logic scan_inc;
        logic take_found;
        logic take_grow;
        logic bm_rd;
        logic bm_wr;
        logic ser_rd;
        logic res_fail;
        logic res_check;
        logic out_load;
    } ght_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_alloc;
        logic op_release;
        logic cat_ok;
        logic pre_ok;
        logic scan_more;
        logic full;
        logic found;
        logic match;
        logic out_free;
    } ght_stat_t;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [WBIT_W-1:0] lowest_one(input logic [WORD_W-1:0] v);
        logic [WBIT_W-1:0] idx;
        idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (v[b]) begin
                idx = WBIT_W'(b);
            end
        end
        return idx;
    endfunction

endpackage

FILE: src/ght_ram.sv
module ght_ram
    #(
        parameter int WIDTH = 32,
        parameter int DEPTH = 64,
        localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic             clk,
        input  logic             we,
        input  logic [AW-1:0]    waddr,
        input  logic [WIDTH-1:0] wdata,
        input  logic             re,
        input  logic [AW-1:0]    raddr,
        output logic [WIDTH-1:0] rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/ght_ctrl.sv
module ght_ctrl
    import ght_pkg::*;
    (
        input  logic      clk,
        input  logic      rst_n,
        input  logic      in_valid,
        output logic      in_ready,
        input  ght_stat_t stat,
        output ght_cmd_t  cmd
    );

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DISPATCH = 9'b000000010,
        S_SCAN     = 9'b000000100,
        S_SCAN_CHK = 9'b000001000,
        S_BM_RD    = 9'b000010000,
        S_BM_WR    = 9'b000100000,
        S_V_RD     = 9'b001000000,
        S_V_CHK    = 9'b010000000,
        S_RESULT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (stat.op_alloc && stat.cat_ok)
                begin
                    state_next = S_SCAN;
                end
                else if (!stat.op_alloc && stat.pre_ok)
                begin
                    state_next = S_V_RD;
                end
                else
                begin
                    cmd.res_fail = 1'b1;
                    state_next   = S_RESULT;
                end
            end
            S_SCAN:
            begin
                priority if (stat.scan_more)
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_CHK;
                end
                else if (!stat.full)
                begin
                    cmd.take_grow = 1'b1;
                    state_next    = S_BM_RD;
                end
                else
                begin
                    cmd.res_fail = 1'b1;
                    state_next   = S_RESULT;
                end
            end
            S_SCAN_CHK:
            begin
                if (stat.found)
                begin
                    cmd.take_found = 1'b1;
                    state_next     = S_BM_RD;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_BM_RD:
            begin
                cmd.bm_rd  = 1'b1;
                state_next = S_BM_WR;
            end
            S_BM_WR:
            begin
                cmd.bm_wr  = 1'b1;
                state_next = S_RESULT;
            end
            S_V_RD:
            begin
                cmd.ser_rd = 1'b1;
                state_next = S_V_CHK;
            end
            S_V_CHK:
            begin
                if (stat.op_release && stat.match)
                begin
                    state_next = S_BM_RD;
                end
                else
                begin
                    cmd.res_check = 1'b1;
                    state_next    = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/ght_dp.sv
module ght_dp
    import ght_pkg::*;
    #(
        parameter int CATEGORIES = 4,
        parameter int ENTRIES    = 1024
    )
    (
        input  logic                clk,
        input  logic                rst_n,
        input  logic [CMD_W-1:0]    command,
        input  logic [CAT_W-1:0]    category,
        input  logic [HANDLE_W-1:0] handle,
        output logic                out_valid,
        input  logic                out_ready,
        output logic [HOUT_W-1:0]   handle_out,
        output logic                ok,
        input  ght_cmd_t            cmd,
        output ght_stat_t           stat
    );

    localparam int WPC   = (ENTRIES + WORD_W - 1) / WORD_W;
    localparam int WC_W  = $clog2(WPC + 1);
    localparam int SDEP  = CATEGORIES * ENTRIES;
    localparam int BDEP  = CATEGORIES * WPC;
    localparam int SA_W  = (SDEP > 1) ? $clog2(SDEP) : 1;
    localparam int BA_W  = (BDEP > 1) ? $clog2(BDEP) : 1;

    logic [CMD_W-1:0]    cmd_reg;
    logic [CAT_W-1:0]    cat_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SERFLD_W-1:0] ser_in_reg;
    logic [WC_W-1:0]     w_reg;
    logic                grow_reg;
    logic [SERIAL_W-1:0] seed_reg;
    logic [USED_W-1:0]   used_reg [CATEGORIES];
    logic                res_ok_reg;
    logic [HOUT_W-1:0]   res_handle_reg;
    logic                out_valid_reg;
    logic [HOUT_W-1:0]   handle_out_reg;
    logic                ok_out_reg;

    logic [USED_W-1:0]   used_cur;
    logic [USED_W-1:0]   base;
    logic                full_word;
    logic [WORD_W-1:0]   mask;
    logic [WORD_W-1:0]   masked;
    logic [SLOT_W-1:0]   found_slot;
    logic [SERIAL_W-1:0] seed_next;
    logic [WORD_W-1:0]   bit_sel;
    logic [WORD_W-1:0]   bm_rdata;
    logic [WORD_W-1:0]   bm_wdata;
    logic [BA_W-1:0]     bm_scan_addr;
    logic [BA_W-1:0]     bm_slot_addr;
    logic [SERIAL_W-1:0] ser_rdata;
    logic [SERIAL_W-1:0] ser_wdata;
    logic [SA_W-1:0]     ser_addr;
    logic                is_alloc;

    assign is_alloc = (cmd_reg == CMD_ALLOC);

    always_comb
    begin
        used_cur = '0;
        for (int c = 0; c < CATEGORIES; c++)
        begin
            if (cat_reg == CAT_W'(c))
            begin
                used_cur = used_reg[c];
            end
        end
    end

    // Scan of the free bitmap, one word per read.
    assign base      = USED_W'({w_reg, {WBIT_W{1'b0}}});
    assign full_word = ({1'b0, base} + (USED_W + 1)'(WORD_W)) <= {1'b0, used_cur};
    assign mask      = full_word ? '1
                                 : ((WORD_W'(1) << used_cur[WBIT_W-1:0]) - WORD_W'(1));
    assign masked    = bm_rdata & mask;
    assign found_slot = base[SLOT_W-1:0] + SLOT_W'(lowest_one(masked));

    assign seed_next = (seed_reg == SERIAL_MAX) ? SERIAL_FIRST : seed_reg + SERIAL_W'(1);
    assign bit_sel   = WORD_W'(1) << slot_reg[WBIT_W-1:0];
    assign bm_wdata  = is_alloc ? (bm_rdata & ~bit_sel) : (bm_rdata | bit_sel);
    assign ser_wdata = is_alloc ? seed_next : '0;

    assign bm_scan_addr = BA_W'(int'(cat_reg) * WPC + int'(w_reg));
    assign bm_slot_addr = BA_W'(int'(cat_reg) * WPC + int'(slot_reg >> WBIT_W));
    assign ser_addr     = SA_W'(int'(cat_reg) * ENTRIES + int'(slot_reg));

    always_comb
    begin
        stat.op_alloc   = is_alloc;
        stat.op_release = (cmd_reg == CMD_RELEASE);
        stat.cat_ok     = {1'b0, cat_reg} < (CAT_W + 1)'(CATEGORIES);
        stat.pre_ok     = stat.cat_ok
                          && (cmd_reg == CMD_RELEASE || cmd_reg == CMD_CHECK)
                          && ({1'b0, slot_reg} < used_cur)
                          && (ser_in_reg != '0)
                          && !ser_in_reg[SERFLD_W-1];
        stat.scan_more  = base < used_cur;
        stat.full       = used_cur >= USED_W'(ENTRIES);
        stat.found      = |masked;
        stat.match      = (ser_rdata == ser_in_reg[SERIAL_W-1:0]);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    ght_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BDEP)
    ) u_bitmap (
        .clk   (clk),
        .we    (cmd.bm_wr),
        .waddr (bm_slot_addr),
        .wdata (bm_wdata),
        .re    (cmd.scan_rd || cmd.bm_rd),
        .raddr (cmd.scan_rd ? bm_scan_addr : bm_slot_addr),
        .rdata (bm_rdata)
    );

    ght_ram #(
        .WIDTH (SERIAL_W),
        .DEPTH (SDEP)
    ) u_serial (
        .clk   (clk),
        .we    (cmd.bm_wr),
        .waddr (ser_addr),
        .wdata (ser_wdata),
        .re    (cmd.ser_rd),
        .raddr (ser_addr),
        .rdata (ser_rdata)
    );

    // Item registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg    <= command;
            cat_reg    <= (command == CMD_ALLOC) ? category : handle[15:14];
            slot_reg   <= handle[SLOT_W-1:0];
            ser_in_reg <= handle[HANDLE_W-1:16];
        end
        else if (cmd.take_found)
        begin
            slot_reg <= found_slot;
        end
        else if (cmd.take_grow)
        begin
            slot_reg <= used_cur[SLOT_W-1:0];
        end

        if (cmd.load)
        begin
            w_reg <= '0;
        end
        else if (cmd.scan_inc)
        begin
            w_reg <= w_reg + WC_W'(1);
        end

        if (cmd.bm_wr)
        begin
            res_ok_reg     <= 1'b1;
            res_handle_reg <= is_alloc ? {seed_next, cat_reg, slot_reg} : '0;
        end
        else if (cmd.res_fail)
        begin
            res_ok_reg     <= 1'b0;
            res_handle_reg <= '0;
        end
        else if (cmd.res_check)
        begin
            res_ok_reg     <= stat.match;
            res_handle_reg <= '0;
        end

        if (cmd.out_load)
        begin
            handle_out_reg <= res_handle_reg;
            ok_out_reg     <= res_ok_reg;
        end
    end

    // Table state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= SERIAL_FIRST;
            grow_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CATEGORIES; c++)
            begin
                used_reg[c] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                grow_reg <= 1'b0;
            end
            else if (cmd.take_grow)
            begin
                grow_reg <= 1'b1;
            end

            if (cmd.bm_wr && is_alloc)
            begin
                seed_reg <= seed_next;
                for (int c = 0; c < CATEGORIES; c++)
                begin
                    if (grow_reg && cat_reg == CAT_W'(c))
                    begin
                        used_reg[c] <= used_cur + USED_W'(1);
                    end
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign handle_out = handle_out_reg;
    assign ok         = ok_out_reg;

endmodule

FILE: src/generational_handle_table.sv
// Generational handle table.
// Input channel (in_valid/in_ready) carries one command item: allocate a
// handle in a category, release a handle, or check that a handle is live.
// Output channel (out_valid/out_ready) returns exactly one item per command:
// handle_out holds the new handle after a successful allocate and is zero
// otherwise; ok tells whether the command succeeded or the handle is live.
// The block works on one item at a time and takes the next one in the cycle
// after the result has moved into the output register. A command rejected at
// dispatch (unused code, bad category, slot or serial field) goes straight to
// the result; a check, or a release whose serial does not match, first reads
// the stored serial; a successful release then also updates the free-slot
// bitmap. An allocate scans the free-slot bitmap one 32-slot word per read,
// takes the first free slot it finds, else grows the used range, and fails
// when the table is full.
// Reset clears the used range of every category and sets the serial seed to
// one. Neither memory is cleared, since only slots inside a used range are
// read, so the block takes items right after reset.
// While the receiver stalls, the block still accepts the next item, works on
// it and holds that second result until the output register is taken.
module generational_handle_table
    import ght_pkg::*;
    #(
        parameter int CATEGORIES = 4,
        parameter int ENTRIES    = 1024
    )
    (
        input  logic                clk,
        input  logic                rst_n,
        input  logic                in_valid,
        output logic                in_ready,
        input  logic [CMD_W-1:0]    command,
        input  logic [CAT_W-1:0]    category,
        input  logic [HANDLE_W-1:0] handle,
        output logic                out_valid,
        input  logic                out_ready,
        output logic [HOUT_W-1:0]   handle_out,
        output logic                ok
    );

    ght_cmd_t  cmd;
    ght_stat_t stat;

    // The controller sequences each command; the datapath holds the tables.
    ght_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ght_dp #(
        .CATEGORIES (CATEGORIES),
        .ENTRIES    (ENTRIES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .command    (command),
        .category   (category),
        .handle     (handle),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .handle_out (handle_out),
        .ok         (ok),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule

FILE: src/ght_checker.sv
module ght_checker
    import ght_pkg::*;
    #(
        parameter int CATEGORIES = 4,
        parameter int ENTRIES    = 1024
    )
    (
        input logic                clk,
        input logic                rst_n,
        input logic                in_valid,
        input logic                in_ready,
        input logic                out_valid,
        input logic                out_ready,
        input logic [HOUT_W-1:0]   handle_out,
        input logic                ok
    );

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(handle_out) && $stable(ok))
        else $error("stalled result changed");

    // A failed command never returns a handle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> handle_out == '0)
        else $error("nonzero handle with ok low");

    // A returned handle has a nonzero serial and lies inside the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && handle_out != '0 |->
            ok && handle_out[30:16] != '0
            && {1'b0, handle_out[SLOT_W-1:0]} < (SLOT_W + 1)'(ENTRIES)
            && {1'b0, handle_out[15:14]} < (CAT_W + 1)'(CATEGORIES))
        else $error("handle out of range");

    // The block takes one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    // An item is not lost: an accepted item yields a result before the next is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !$past(in_ready) |-> out_valid || $past(out_valid))
        else $error("item finished without a result");

endmodule

bind generational_handle_table ght_checker #(
    .CATEGORIES (CATEGORIES),
    .ENTRIES    (ENTRIES)
) u_ght_checker (.*);
